// ===== design/kmcs_pkg.sv =====
package kmcs_pkg;

   // fixed field widths
   localparam int SAMPLE_W    = 16;
   localparam int DIST_W      = SAMPLE_W + 1;
   localparam int RANK_W      = 4;
   localparam int INDEX_W     = 8;
   localparam int CFG_COUNT_W = 9;
   localparam int CFG_GAP_W   = 15;
   localparam int CFG_LIMIT_W = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT        = 2'd2;

   // register reset values
   localparam logic [CFG_COUNT_W-1:0] RST_SAMPLE_COUNT = 9'd100;
   localparam logic [CFG_GAP_W-1:0]   RST_GAP          = 15'd4;
   localparam logic [CFG_LIMIT_W-1:0] RST_LIMIT        = 8'd255;

   // seeding starts this many samples into the store
   localparam int SEED_OFFSET = 3;

   typedef struct packed {
      logic                       cmd;
      logic [INDEX_W-1:0]         sample_index;
      logic signed [SAMPLE_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0]          cluster_rank;
      logic signed [SAMPLE_W-1:0] center_value;
      logic [SAMPLE_W-1:0]        spread_value;
      logic                       converged;
      logic                       last;
   } rsp_type;

   // sample travelling down the chain with the best match so far
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic [DIST_W-1:0]          near_d;
      logic [RANK_W-1:0]          idx;
   } tok_type;

   // broadcast control to every cell
   typedef struct packed {
      logic                       clear;
      logic                       load_en;
      logic [RANK_W-1:0]          load_idx;
      logic signed [SAMPLE_W-1:0] load_val;
      logic                       sort_en;
      logic                       sort_phase;
      logic                       shift_en;
   } ctl_type;

   // |a - b| of two signed samples
   function automatic logic [DIST_W-1:0] abs_diff(logic signed [SAMPLE_W-1:0] a,
                                                  logic signed [SAMPLE_W-1:0] b);
      logic [DIST_W-1:0] d;
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      return d[DIST_W-1] ? (~d + 1'b1) : d;
   endfunction

endpackage

// ===== design/kmcs_ram.sv =====
module kmcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== design/kmcs_cell.sv =====
module kmcs_cell import kmcs_pkg::*; #(
   parameter int CELL_ID  = 0,
   parameter int CLUSTERS = 10,
   parameter int SUM_W    = 24,
   parameter int CNT_W    = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_type                    ctl,
   input  tok_type                    tok_in,
   output tok_type                    tok_out_ff,
   input  tok_type                    acc,
   input  logic signed [SAMPLE_W-1:0] left_center,
   input  logic signed [SAMPLE_W-1:0] right_center,
   output logic signed [SAMPLE_W-1:0] center_ff,
   output logic signed [SUM_W-1:0]    sum_ff,
   output logic [CNT_W-1:0]           count_ff
);

   localparam logic [RANK_W-1:0] MY_ID  = RANK_W'(CELL_ID);
   localparam logic              ID_ODD = 1'(CELL_ID % 2);
   localparam logic              HAS_R  = (CELL_ID + 1 < CLUSTERS);
   localparam logic              HAS_L  = (CELL_ID > 0);

   tok_type                    tok_in_nx;
   logic [DIST_W-1:0]          cur_d;
   logic signed [SAMPLE_W-1:0] center_in;
   logic signed [SUM_W-1:0]    sum_in;
   logic [CNT_W-1:0]           count_in;

   // nearest-center compare; strict less keeps the lower-numbered center on a tie
   always_comb begin
      cur_d     = abs_diff(tok_in.sample, center_ff);
      tok_in_nx = tok_in;
      if (cur_d < tok_in.near_d) begin
         tok_in_nx.near_d = cur_d;
         tok_in_nx.idx    = MY_ID;
      end
   end

   // member accumulation from the chain tail
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         sum_in   = '0;
         count_in = '0;
      end else if (acc.valid && acc.idx == MY_ID) begin
         sum_in   = sum_ff + {{(SUM_W-SAMPLE_W){acc.sample[SAMPLE_W-1]}}, acc.sample};
         count_in = count_ff + 1'b1;
      end
   end

   // center: load, odd-even compare-exchange, or shift toward the head
   always_comb begin
      center_in = center_ff;
      if (ctl.load_en && ctl.load_idx == MY_ID) begin
         center_in = ctl.load_val;
      end else if (ctl.sort_en) begin
         if (HAS_R && ID_ODD == ctl.sort_phase) begin
            if (right_center < center_ff) begin
               center_in = right_center;
            end
         end else if (HAS_L && ID_ODD != ctl.sort_phase) begin
            if (left_center > center_ff) begin
               center_in = left_center;
            end
         end
      end else if (ctl.shift_en && HAS_R) begin
         center_in = right_center;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff <= '0;
         center_ff  <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         tok_out_ff <= tok_in_nx;
         center_ff  <= center_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ===== design/kmeans_1d_center_spread.sv =====
// One-dimensional k-means block.
// req channel (valid/stall): a load item (cmd = load) writes sample_value into
// the sample store at sample_index; indexes past the store are dropped.
// A run item seeds the centers from strided samples, runs
// Lloyd passes until no center moves more than the gap or the pass limit is
// hit, sorts the centers and returns CLUSTERS result items on rsp, in rank
// order, the final one flagged with last.
// The pass time is set by the row of cells (one sample enters per cycle) and
// by the shared bit-serial divider that forms each rounded mean. req_stall is
// high from a run's acceptance until its last result is in the output register.
// csr port: plain write, taken whenever csr_wr_en is high; write only idle.
// Reset clears the configuration to its defaults, the centers, the
// sums and all control; the sample store is not cleared.
// A stalled rsp holds its item; emission waits for the receiver.
module kmeans_1d_center_spread import kmcs_pkg::*; #(
   parameter int MAX_SAMPLES = 256,
   parameter int CLUSTERS    = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int NW    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_W + AW;
   localparam int DIV_W = SUM_W + 1;
   localparam int DCW   = $clog2(DIV_W);
   localparam int IW    = $clog2(CLUSTERS);
   localparam int KW    = $clog2(CLUSTERS + 2);
   localparam int CMP_W = (NW > CFG_COUNT_W) ? NW : CFG_COUNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_SEED, S_CLEAR, S_PASS, S_DRAIN,
      S_DIV_PICK, S_DIV_RUN, S_DIV_END, S_SORT, S_EMIT
   } state_type;

   state_type                  state_ff;
   logic [CFG_COUNT_W-1:0]     count_cfg_ff;
   logic [CFG_GAP_W-1:0]       gap_ff;
   logic [CFG_LIMIT_W-1:0]     limit_ff;
   logic [NW-1:0]              n_ff, stride_ff, rest_ff, addr_ff;
   logic [IW-1:0]              idx_ff;
   logic [KW-1:0]              cnt_ff;
   logic [CFG_LIMIT_W-1:0]     pass_ff;
   logic                       moved_ff, conv_ff;
   logic                       seed_wr_ff, tok_vld_ff;
   logic [IW-1:0]              seed_idx_ff;
   logic [DIV_W-1:0]           dvd_ff, quo_ff;
   logic [NW-1:0]              rem_ff;
   logic                       neg_ff;
   logic [DCW-1:0]             dstep_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff;

   logic                       req_take, load_take;
   logic [AW-1:0]              rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   ctl_type                    ctl;
   tok_type                    tok_link [CLUSTERS+1];
   logic signed [SAMPLE_W-1:0] cell_center [CLUSTERS];
   logic signed [SUM_W-1:0]    cell_sum [CLUSTERS];
   logic [NW-1:0]              cell_count [CLUSTERS];

   logic [NW-1:0]              n_clamp;
   logic [NW:0]                seed_step;
   logic signed [SUM_W-1:0]    pick_sum;
   logic [NW-1:0]              pick_count;
   logic [SUM_W-1:0]           pick_mag;
   logic [NW:0]                rem_try;
   logic signed [SAMPLE_W-1:0] mean_val;
   logic                       moved_now;
   logic [CFG_LIMIT_W:0]       pass_next;
   logic [CFG_LIMIT_W-1:0]     limit_eff;
   logic                       emit_go;
   logic [DIST_W-1:0]          d_next, d_prev, spread;

   assign req_take  = req_valid && !req_stall;
   assign load_take = req_take && req_data.cmd == CMD_LOAD &&
                      int'(req_data.sample_index) < MAX_SAMPLES;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sample store
   kmcs_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
      .clock      (clock),
      .wr_en      (load_take),
      .wr_addr    (AW'(req_data.sample_index)),
      .wr_data    (req_data.sample_value),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );
   assign rd_addr = AW'(addr_ff);

   // head of the chain: sample read last cycle, no match yet
   always_comb begin
      tok_link[0].valid  = tok_vld_ff;
      tok_link[0].sample = rd_data;
      tok_link[0].near_d = '1;
      tok_link[0].idx    = '0;
   end

   // row of cells
   for (genvar g = 0; g < CLUSTERS; g++) begin : g_cell
      logic signed [SAMPLE_W-1:0] left_c, right_c;
      assign left_c  = cell_center[(g > 0) ? g - 1 : g];
      assign right_c = cell_center[(g + 1 < CLUSTERS) ? g + 1 : g];
      kmcs_cell #(.CELL_ID(g), .CLUSTERS(CLUSTERS), .SUM_W(SUM_W), .CNT_W(NW)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .tok_in       (tok_link[g]),
         .tok_out_ff   (tok_link[g+1]),
         .acc          (tok_link[CLUSTERS]),
         .left_center  (left_c),
         .right_center (right_c),
         .center_ff    (cell_center[g]),
         .sum_ff       (cell_sum[g]),
         .count_ff     (cell_count[g])
      );
   end

   // clamped sample count
   always_comb begin
      if (count_cfg_ff == '0) begin
         n_clamp = NW'(1);
      end else if (CMP_W'(count_cfg_ff) > CMP_W'(MAX_SAMPLES)) begin
         n_clamp = NW'(MAX_SAMPLES);
      end else begin
         n_clamp = NW'(count_cfg_ff);
      end
   end

   // datapath helpers
   always_comb begin
      seed_step  = {1'b0, addr_ff} + {1'b0, stride_ff};
      pick_sum   = cell_sum[idx_ff];
      pick_count = cell_count[idx_ff];
      pick_mag   = pick_sum[SUM_W-1] ? SUM_W'(-pick_sum) : SUM_W'(pick_sum);
      rem_try    = {rem_ff, dvd_ff[DIV_W-1]};
      mean_val   = neg_ff ? SAMPLE_W'(-quo_ff) : SAMPLE_W'(quo_ff);
      moved_now  = moved_ff ||
                   (abs_diff(mean_val, cell_center[idx_ff]) > DIST_W'(gap_ff));
      pass_next  = {1'b0, pass_ff} + 1'b1;
      limit_eff  = (limit_ff == '0) ? CFG_LIMIT_W'(1) : limit_ff;
      emit_go    = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
      d_next     = abs_diff(cell_center[1], cell_center[0]);
      d_prev     = abs_diff(cell_center[0], prev_ff);
      if (idx_ff == '0) begin
         spread = d_next;
      end else if (idx_ff == IW'(CLUSTERS - 1)) begin
         spread = d_prev;
      end else begin
         spread = (d_prev < d_next) ? d_prev : d_next;
      end
   end

   // cell control
   always_comb begin
      ctl            = '0;
      ctl.clear      = (state_ff == S_CLEAR);
      ctl.sort_en    = (state_ff == S_SORT);
      ctl.sort_phase = cnt_ff[0];
      ctl.shift_en   = emit_go;
      if (seed_wr_ff) begin
         ctl.load_en  = 1'b1;
         ctl.load_idx = RANK_W'(seed_idx_ff);
         ctl.load_val = rd_data;
      end else if (state_ff == S_DIV_END) begin
         ctl.load_en  = 1'b1;
         ctl.load_idx = RANK_W'(idx_ff);
         ctl.load_val = mean_val;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_cfg_ff <= RST_SAMPLE_COUNT;
         gap_ff       <= RST_GAP;
         limit_ff     <= RST_LIMIT;
         seed_wr_ff   <= 1'b0;
         tok_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         pass_ff      <= '0;
         moved_ff     <= 1'b0;
         conv_ff      <= 1'b0;
         dstep_ff     <= '0;
      end else begin
         seed_wr_ff <= (state_ff == S_SEED);
         tok_vld_ff <= (state_ff == S_PASS);
         if (rsp_valid_ff && !rsp_stall && !emit_go) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_COUNT: count_cfg_ff <= CFG_COUNT_W'(csr_wr_data);
               CSR_GAP:          gap_ff       <= CFG_GAP_W'(csr_wr_data);
               CSR_LIMIT:        limit_ff     <= CFG_LIMIT_W'(csr_wr_data);
               default:          ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take && req_data.cmd == CMD_RUN) begin
                  n_ff      <= n_clamp;
                  rest_ff   <= n_clamp;
                  stride_ff <= '0;
                  addr_ff   <= NW'(SEED_OFFSET);
                  state_ff  <= S_PREP;
               end
            end
            // stride = n / CLUSTERS and first seed address mod n, by subtraction
            S_PREP: begin
               if (rest_ff >= NW'(CLUSTERS)) begin
                  rest_ff   <= rest_ff - NW'(CLUSTERS);
                  stride_ff <= stride_ff + 1'b1;
               end
               if (addr_ff >= n_ff) begin
                  addr_ff <= addr_ff - n_ff;
               end
               if (rest_ff < NW'(CLUSTERS) && addr_ff < n_ff) begin
                  if (stride_ff == '0) begin
                     stride_ff <= NW'(1);
                  end
                  idx_ff   <= '0;
                  state_ff <= S_SEED;
               end
            end
            S_SEED: begin
               seed_idx_ff <= idx_ff;
               addr_ff     <= (seed_step >= {1'b0, n_ff}) ? NW'(seed_step - {1'b0, n_ff})
                                                           : NW'(seed_step);
               idx_ff      <= idx_ff + 1'b1;
               if (idx_ff == IW'(CLUSTERS - 1)) begin
                  pass_ff  <= '0;
                  state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               addr_ff  <= '0;
               state_ff <= S_PASS;
            end
            S_PASS: begin
               addr_ff    <= addr_ff + 1'b1;
               if (addr_ff == n_ff - 1'b1) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DRAIN;
               end
            end
            // let the last sample reach the tail and accumulate
            S_DRAIN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == KW'(CLUSTERS + 1)) begin
                  idx_ff   <= '0;
                  moved_ff <= 1'b0;
                  state_ff <= S_DIV_PICK;
               end
            end
            S_DIV_PICK: begin
               if (pick_count == '0) begin
                  // empty cluster keeps its center
                  if (idx_ff == IW'(CLUSTERS - 1)) begin
                     pass_ff <= CFG_LIMIT_W'(pass_next);
                     if (!moved_ff) begin
                        conv_ff  <= 1'b1;
                        cnt_ff   <= '0;
                        state_ff <= S_SORT;
                     end else if (pass_next >= {1'b0, limit_eff}) begin
                        conv_ff  <= 1'b0;
                        cnt_ff   <= '0;
                        state_ff <= S_SORT;
                     end else begin
                        state_ff <= S_CLEAR;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  neg_ff   <= pick_sum[SUM_W-1];
                  dvd_ff   <= {1'b0, pick_mag} + DIV_W'(pick_count >> 1);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  dstep_ff <= '0;
                  state_ff <= S_DIV_RUN;
               end
            end
            // restoring division, one quotient bit per cycle
            S_DIV_RUN: begin
               dvd_ff   <= dvd_ff << 1;
               dstep_ff <= dstep_ff + 1'b1;
               if (rem_try >= {1'b0, pick_count}) begin
                  rem_ff <= NW'(rem_try - {1'b0, pick_count});
                  quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
               end else begin
                  rem_ff <= NW'(rem_try);
                  quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
               end
               if (dstep_ff == DCW'(DIV_W - 1)) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               moved_ff <= moved_now;
               if (idx_ff == IW'(CLUSTERS - 1)) begin
                  pass_ff <= CFG_LIMIT_W'(pass_next);
                  if (!moved_now) begin
                     conv_ff  <= 1'b1;
                     cnt_ff   <= '0;
                     state_ff <= S_SORT;
                  end else if (pass_next >= {1'b0, limit_eff}) begin
                     conv_ff  <= 1'b0;
                     cnt_ff   <= '0;
                     state_ff <= S_SORT;
                  end else begin
                     state_ff <= S_CLEAR;
                  end
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_DIV_PICK;
               end
            end
            // odd-even transposition, one phase per cycle
            S_SORT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == KW'(CLUSTERS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= S_EMIT;
               end
            end
            // head cell is the next center; the row shifts toward it
            S_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.cluster_rank <= RANK_W'(idx_ff);
                  rsp_ff.center_value <= cell_center[0];
                  rsp_ff.spread_value <= SAMPLE_W'(spread);
                  rsp_ff.converged    <= conv_ff;
                  rsp_ff.last         <= (idx_ff == IW'(CLUSTERS - 1));
                  prev_ff             <= cell_center[0];
                  idx_ff              <= idx_ff + 1'b1;
                  if (idx_ff == IW'(CLUSTERS - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== design/kmcs_checker.sv =====
module kmcs_checker import kmcs_pkg::*; #(
   parameter int CLUSTERS = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed under stall");

   // a run blocks further items
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_RUN |=> req_stall)
      else $error("run item not followed by busy");

   // nothing follows the last item of a run at once
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid)
      else $error("item right after last");

   // rank within the cluster count, last only on the top rank
   a_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_data.cluster_rank) < CLUSTERS &&
      (rsp_data.last == (int'(rsp_data.cluster_rank) == CLUSTERS - 1)))
      else $error("bad rank or last flag");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind kmeans_1d_center_spread kmcs_checker #(.CLUSTERS(CLUSTERS)) u_kmcs_checker (.*);
